// ===== hw/rtl/serial_bus_byte_transceiver_top_assert.svh =====
// ----------------------------------------------------------------------------
// serial_bus_byte_transceiver_top_assert
// Assertion macros for the serial bus byte transceiver. Each macro samples
// on clk and is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef SERIAL_BUS_BYTE_TRANSCEIVER_TOP_ASSERT_SVH
`define SERIAL_BUS_BYTE_TRANSCEIVER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SBBT_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define SBBT_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define SBBT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SBBT_ASSERT_NOW(label, cond, msg)
`define SBBT_ASSERT_IMP(label, pre, post, msg)
`define SBBT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/sbbt_pkg.sv =====
// ----------------------------------------------------------------------------
// sbbt_pkg
// Shared types, codes and reset values of the serial bus byte transceiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbbt_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_SEND = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_ABORT   = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WAIT_LIMIT  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EOI_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EOI_ACK     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BIT_DELAY   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SEND_LEAD   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RECV_TAIL   = 3'd5;

  localparam logic [15:0] WAIT_LIMIT_RESET = 16'd50000;
  localparam logic [15:0] EOI_LIMIT_RESET  = 16'd200;
  localparam logic [7:0]  EOI_ACK_RESET    = 8'd4;
  localparam logic [7:0]  BIT_DELAY_RESET  = 8'd4;
  localparam logic [7:0]  SEND_LEAD_RESET  = 8'd10;
  localparam logic [7:0]  RECV_TAIL_RESET  = 8'd5;

  typedef struct packed {
    logic [15:0] wait_limit;
    logic [15:0] eoi_limit;
    logic [7:0]  eoi_ack;
    logic [7:0]  bit_delay;
    logic [7:0]  send_lead;
    logic [7:0]  recv_tail;
  } cfg_t;

  typedef struct packed {
    logic       clock_drive;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] received_byte;
    logic       end_flag;
    logic [1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbbt_core.sv =====
// ----------------------------------------------------------------------------
// sbbt_core
// Byte handshake sequencer: one step per accepted line sample, result
// produced combinationally from the sample and the held state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "serial_bus_byte_transceiver_top_assert.svh"

module sbbt_core #(
  parameter int COUNT_BITS = sbbt_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [1:0]       command,
  input  wire logic [7:0]       send_byte,
  input  wire logic             send_last,
  input  wire logic             clock_line,
  input  wire logic             data_line,
  input  wire sbbt_pkg::cfg_t   cfg,
  output sbbt_pkg::result_t     res
);

  localparam int CMP_BITS = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  typedef enum logic [4:0] {
    P_IDLE,
    R_CLK_LOW0, R_CLK_HIGH0, R_EOI_WAIT, R_EOI_ACK, R_EOI_CLK_LOW,
    R_BIT_HIGH, R_BIT_LOW, R_TAIL,
    S_LEAD, S_DLOW_A, S_DLOW_B, S_DHIGH, S_DLOW_C, S_SETTLE, S_CLK_LOW, S_END
  } phase_t;

  phase_t                phase, phase_next, ph_eff;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next, tc_base, tc_wait, tc_inc, tc_dly;
  logic [2:0]            bit_index, bit_index_next, bi_b;
  logic [7:0]            shift_byte, shift_byte_next, sb_b;
  logic                  eoi_mark, eoi_mark_next, em_b;
  logic                  clock_out, clock_out_next;
  logic                  data_out, data_out_next;
  logic                  soft_timeout, soft_timeout_next, soft_b;
  logic                  start_recv, start_send;
  logic                  w_line, w_want, w_hit, w_exp, d_done;
  logic [15:0]           w_lim, d_lim;
  logic                  fin;
  logic [7:0]            fin_byte;
  logic                  fin_end;
  logic [1:0]            fin_status;

  function automatic logic expired(input logic [COUNT_BITS-1:0] t, input logic [15:0] lim);
    expired = (CMP_BITS'(t) >= CMP_BITS'(lim)) || (&t);
  endfunction

  assign start_recv = (phase == P_IDLE) && (command == sbbt_pkg::CMD_RECV);
  assign start_send = (phase == P_IDLE) && (command == sbbt_pkg::CMD_SEND);

  always_comb begin
    ph_eff  = phase;
    tc_base = tick_count;
    bi_b    = bit_index;
    sb_b    = shift_byte;
    em_b    = eoi_mark;
    soft_b  = soft_timeout;
    if (start_recv) begin
      ph_eff  = R_CLK_LOW0;
      tc_base = '0;
      bi_b    = '0;
      sb_b    = '0;
      em_b    = 1'b0;
      soft_b  = 1'b0;
    end else if (start_send) begin
      ph_eff  = S_LEAD;
      tc_base = '0;
      bi_b    = '0;
      sb_b    = send_byte;
      em_b    = send_last;
    end
  end

  always_comb begin
    w_line = clock_line;
    w_want = 1'b0;
    w_lim  = cfg.wait_limit;
    d_lim  = {8'd0, cfg.bit_delay};
    unique case (ph_eff)
      R_CLK_HIGH0, R_BIT_HIGH: w_want = 1'b1;
      R_EOI_WAIT:              w_lim  = cfg.eoi_limit;
      S_DLOW_A, S_DLOW_B, S_DLOW_C: w_line = data_line;
      S_DHIGH, S_END: begin
        w_line = data_line;
        w_want = 1'b1;
      end
      R_EOI_ACK: d_lim = {8'd0, cfg.eoi_ack};
      R_TAIL:    d_lim = {8'd0, cfg.recv_tail};
      S_LEAD:    d_lim = {8'd0, cfg.send_lead};
      default: ;
    endcase
  end

  assign w_hit   = (w_line == w_want);
  assign w_exp   = !w_hit && expired(tc_base, w_lim);
  assign tc_wait = (w_hit || w_exp) ? '0 : tc_base + COUNT_BITS'(1);
  assign tc_inc  = (&tc_base) ? tc_base : tc_base + COUNT_BITS'(1);
  assign d_done  = expired(tc_inc, d_lim);
  assign tc_dly  = d_done ? '0 : tc_inc;

  always_comb begin
    phase_next        = ph_eff;
    tick_count_next   = tc_base;
    bit_index_next    = bi_b;
    shift_byte_next   = sb_b;
    eoi_mark_next     = em_b;
    clock_out_next    = clock_out;
    data_out_next     = data_out;
    soft_timeout_next = soft_b;
    fin               = 1'b0;
    fin_byte          = '0;
    fin_end           = 1'b0;
    fin_status        = sbbt_pkg::ST_OK;
    unique case (ph_eff)
      P_IDLE: ;
      R_CLK_LOW0: begin
        tick_count_next = tc_wait;
        if (w_hit || w_exp) begin
          if (w_exp) soft_timeout_next = 1'b1;
          data_out_next = 1'b0;
          phase_next    = R_CLK_HIGH0;
        end
      end
      R_CLK_HIGH0: begin
        tick_count_next = tc_wait;
        if (w_hit || w_exp) begin
          data_out_next = 1'b1;
          if (w_exp) begin
            fin        = 1'b1;
            fin_status = sbbt_pkg::ST_TIMEOUT;
            phase_next = P_IDLE;
          end else begin
            phase_next = R_EOI_WAIT;
          end
        end
      end
      R_EOI_WAIT: begin
        tick_count_next = tc_wait;
        if (w_hit) begin
          bit_index_next = '0;
          phase_next     = R_BIT_HIGH;
        end else if (w_exp) begin
          eoi_mark_next = 1'b1;
          data_out_next = 1'b0;
          phase_next    = R_EOI_ACK;
        end
      end
      R_EOI_ACK: begin
        tick_count_next = tc_dly;
        if (d_done) begin
          data_out_next = 1'b1;
          phase_next    = R_EOI_CLK_LOW;
        end
      end
      R_EOI_CLK_LOW: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          bit_index_next = '0;
          phase_next     = R_BIT_HIGH;
        end
      end
      R_BIT_HIGH: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          if (data_line) shift_byte_next[bi_b] = 1'b1;
          phase_next = R_BIT_LOW;
        end
      end
      R_BIT_LOW: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          if (&bi_b) begin
            data_out_next = 1'b0;
            if (em_b) clock_out_next = 1'b0;
            phase_next = R_TAIL;
          end else begin
            bit_index_next = bi_b + 3'd1;
            phase_next     = R_BIT_HIGH;
          end
        end
      end
      R_TAIL: begin
        tick_count_next = tc_dly;
        if (d_done) begin
          fin        = 1'b1;
          fin_status = soft_b ? sbbt_pkg::ST_TIMEOUT : sbbt_pkg::ST_OK;
          fin_byte   = sb_b;
          fin_end    = em_b;
          phase_next = P_IDLE;
        end
      end
      S_LEAD: begin
        tick_count_next = tc_dly;
        if (d_done) begin
          clock_out_next = 1'b0;
          if (data_line) begin
            phase_next = S_DLOW_A;
          end else begin
            eoi_mark_next = 1'b1;
            phase_next    = S_DLOW_B;
          end
        end
      end
      S_DLOW_A: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          if (em_b) begin
            phase_next = S_DLOW_B;
          end else begin
            clock_out_next = 1'b1;
            phase_next     = S_DLOW_C;
          end
        end
      end
      S_DLOW_B: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          phase_next = S_DHIGH;
        end
      end
      S_DHIGH: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          clock_out_next = 1'b1;
          phase_next     = S_DLOW_C;
        end
      end
      S_DLOW_C: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          bit_index_next = '0;
          phase_next     = S_SETTLE;
        end
      end
      S_SETTLE: begin
        tick_count_next = tc_dly;
        if (d_done) begin
          if (data_line) begin
            fin        = 1'b1;
            fin_status = sbbt_pkg::ST_ABORT;
            phase_next = P_IDLE;
          end else begin
            data_out_next  = ~sb_b[bi_b];
            clock_out_next = 1'b0;
            phase_next     = S_CLK_LOW;
          end
        end
      end
      S_CLK_LOW: begin
        tick_count_next = tc_dly;
        if (d_done) begin
          clock_out_next = 1'b1;
          data_out_next  = 1'b0;
          if (&bi_b) begin
            phase_next = S_END;
          end else begin
            bit_index_next = bi_b + 3'd1;
            phase_next     = S_SETTLE;
          end
        end
      end
      S_END: begin
        tick_count_next = tc_wait;
        if (w_exp) begin
          fin        = 1'b1;
          fin_status = sbbt_pkg::ST_TIMEOUT;
          phase_next = P_IDLE;
        end else if (w_hit) begin
          fin        = 1'b1;
          fin_end    = em_b;
          phase_next = P_IDLE;
        end
      end
      default: phase_next = P_IDLE;
    endcase
    if (fin) tick_count_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= P_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      shift_byte   <= '0;
      eoi_mark     <= 1'b0;
      clock_out    <= 1'b1;
      data_out     <= 1'b1;
      soft_timeout <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      shift_byte   <= shift_byte_next;
      eoi_mark     <= eoi_mark_next;
      clock_out    <= clock_out_next;
      data_out     <= data_out_next;
      soft_timeout <= soft_timeout_next;
    end
  end

  always_comb begin
    res.clock_drive   = clock_out_next;
    res.data_drive    = data_out_next;
    res.busy_res      = (phase_next != P_IDLE);
    res.done_res      = fin;
    res.received_byte = fin_byte;
    res.end_flag      = fin_end;
    res.status        = fin_status;
  end

  `SBBT_ASSERT_NOW(a_done_not_busy, !(res.done_res && res.busy_res),
                   "transfer finished but sequencer still busy")
  `SBBT_ASSERT_NOW(a_status_only_done, res.done_res || (res.status == sbbt_pkg::ST_OK),
                   "status raised without a finished transfer")
  `SBBT_ASSERT_NEXT(a_idle_tick_stays,
                    step && (phase == P_IDLE) && (command != sbbt_pkg::CMD_RECV)
                      && (command != sbbt_pkg::CMD_SEND),
                    (phase == P_IDLE) && $stable(clock_out) && $stable(data_out),
                    "plain tick in idle changed sequencer state")

endmodule

`default_nettype wire

// ===== hw/rtl/sbbt_skid.sv =====
// ----------------------------------------------------------------------------
// sbbt_skid
// Result register with one skid entry: takes a result while the output
// holds a stalled one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "serial_bus_byte_transceiver_top_assert.svh"

module sbbt_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sbbt_pkg::result_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sbbt_pkg::result_t      out_data
);

  logic              skid_valid;
  sbbt_pkg::result_t skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_data  <= in_data;
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

  `SBBT_ASSERT_NOW(a_skid_behind_out, !skid_valid || out_valid,
                   "skid entry held while output register empty")
  `SBBT_ASSERT_NEXT(a_skid_drains, skid_valid && out_ready, out_valid && !skid_valid,
                    "skid entry not moved to output")

endmodule

`default_nettype wire

// ===== hw/rtl/serial_bus_byte_transceiver_top.sv =====
// ----------------------------------------------------------------------------
// serial_bus_byte_transceiver_top
// Device-side byte handshake on a clock/data/attention serial bus.
// ----------------------------------------------------------------------------
// Each request on the s_ group is one 20 us line sample with a command in
// s_tuser (plain tick, start receive, start send); the send byte and the
// sampled clock and data levels sit in s_tdata, s_tlast asks for EOI on send.
// Every request yields exactly one result on the m_ group: the line drive
// levels, busy and done, the received byte and the status in m_tdata, the
// EOI flag in m_tlast.
// Each result is registered; one request per cycle is taken while s_tready is
// high, set by the single sequencer step between the state registers and the
// result register. When m_tready is low, one more request is taken into the
// skid entry and s_tready then drops until the output drains. Timeouts and
// delays come from six registers written on the cfg_ channel (cfg_ready is
// always high); the user must write them only while no transfer is running,
// which the block itself does not enforce. Reset loads the register defaults,
// releases both lines, idles the sequencer and empties the result path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_bus_byte_transceiver_top #(
  parameter int COUNT_BITS = sbbt_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [7:0] send_byte, [8] clock_line, [9] data_line, [15:10] zero
  input  wire logic [15:0]                         s_tdata,
  // [1:0] command
  input  wire logic [1:0]                          s_tuser,
  input  wire logic                                s_tlast,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [0] clock_drive, [1] data_drive, [2] busy_res, [3] done_res,
  // [11:4] received_byte, [13:12] status, [15:14] zero
  output logic [15:0]                              m_tdata,
  output logic                                     m_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sbbt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [sbbt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  sbbt_pkg::cfg_t    cfg;
  sbbt_pkg::result_t core_res, out_res;
  logic              step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wait_limit <= sbbt_pkg::WAIT_LIMIT_RESET;
      cfg.eoi_limit  <= sbbt_pkg::EOI_LIMIT_RESET;
      cfg.eoi_ack    <= sbbt_pkg::EOI_ACK_RESET;
      cfg.bit_delay  <= sbbt_pkg::BIT_DELAY_RESET;
      cfg.send_lead  <= sbbt_pkg::SEND_LEAD_RESET;
      cfg.recv_tail  <= sbbt_pkg::RECV_TAIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sbbt_pkg::REG_WAIT_LIMIT: cfg.wait_limit <= cfg_data;
        sbbt_pkg::REG_EOI_LIMIT:  cfg.eoi_limit  <= cfg_data;
        sbbt_pkg::REG_EOI_ACK:    cfg.eoi_ack    <= cfg_data[7:0];
        sbbt_pkg::REG_BIT_DELAY:  cfg.bit_delay  <= cfg_data[7:0];
        sbbt_pkg::REG_SEND_LEAD:  cfg.send_lead  <= cfg_data[7:0];
        sbbt_pkg::REG_RECV_TAIL:  cfg.recv_tail  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign step = s_tvalid && s_tready;

  sbbt_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .command    (s_tuser),
    .send_byte  (s_tdata[7:0]),
    .send_last  (s_tlast),
    .clock_line (s_tdata[8]),
    .data_line  (s_tdata[9]),
    .cfg        (cfg),
    .res        (core_res)
  );

  sbbt_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (step),
    .in_ready  (s_tready),
    .in_data   (core_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {2'b00, out_res.status, out_res.received_byte, out_res.done_res,
                    out_res.busy_res, out_res.data_drive, out_res.clock_drive};
  assign m_tlast = out_res.end_flag;

endmodule

`default_nettype wire
